// ===== rtl/infix_to_postfix_converter_macros.svh =====
// Assertion macros used by the converter's stack engine.
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
`define ITP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define ITP_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define ITP_ASSERT(label, prop, msg)
`define ITP_NEVER(label, cond, msg)
`endif

`endif

// ===== rtl/itp_pkg.sv =====
// Shared types, character codes and precedence function of the converter.
package itp_pkg;

   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_NUL    = 8'h00;

   typedef logic [2:0] cls_type;

   localparam cls_type CLS_IGNORE = 3'd0;
   localparam cls_type CLS_DIGIT  = 3'd1;
   localparam cls_type CLS_OPEN   = 3'd2;
   localparam cls_type CLS_CLOSE  = 3'd3;
   localparam cls_type CLS_OPER   = 3'd4;
   localparam cls_type CLS_END    = 3'd5;

   typedef logic [1:0] prec_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      cls_type    cls;
      logic [7:0] symbol;
   } entry_type;

   function automatic prec_type prec_of(input logic [7:0] ch);
      prec_type p;
      case (ch)
         CH_CARET:          p = 2'd3;
         CH_STAR, CH_SLASH: p = 2'd2;
         CH_PLUS, CH_MINUS: p = 2'd1;
         default:           p = 2'd0;
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/itp_front.sv =====
// Front end: accepts input transfers, classifies them and feeds the queue.
module itp_front
   import itp_pkg::*;
(
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_symbol,
   input  logic       req_end_of_input,
   input  logic       queue_full,
   output logic       enq_valid,
   output entry_type  enq_entry
);

   cls_type cls;

   always_comb begin
      if (req_end_of_input) begin
         cls = CLS_END;
      end else if (req_symbol inside {[CH_ZERO:CH_NINE]}) begin
         cls = CLS_DIGIT;
      end else if (req_symbol == CH_LPAREN) begin
         cls = CLS_OPEN;
      end else if (req_symbol == CH_RPAREN) begin
         cls = CLS_CLOSE;
      end else if (req_symbol inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET}) begin
         cls = CLS_OPER;
      end else begin
         cls = CLS_IGNORE;
      end
   end

   assign req_ready        = !queue_full;
   // drop ignored characters at the door
   assign enq_valid        = req_valid && req_ready && (cls != CLS_IGNORE);
   assign enq_entry.cls    = cls;
   assign enq_entry.symbol = req_symbol;

endmodule

// ===== rtl/itp_queue.sv =====
// Short queue of classified items between front end and stack engine.
module itp_queue
   import itp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      enq_valid,
   input  entry_type enq_entry,
   output logic      full,
   input  logic      deq,
   output logic      head_valid,
   output entry_type head_entry
);

   entry_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_deq;

   assign full       = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_deq     = deq && head_valid;

   always_comb begin
      wr_ptr_in = enq_valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_deq ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(enq_valid) - QCNT_W'(do_deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq_valid) begin
         entries_ff[wr_ptr_ff] <= enq_entry;
      end
   end

endmodule

// ===== rtl/itp_exec.sv =====
// Stack engine: one step per cycle unless a result waits; registered results.
module itp_exec
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head_entry,
   output logic       deq,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_symbol,
   output logic       rsp_last_of_run,
   output logic       rsp_terminator,
   output logic       rsp_overflow_seen
);

`include "infix_to_postfix_converter_macros.svh"

   localparam int AW    = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   logic [7:0]       mem [STACK_DEPTH];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       top_ff, top_in;
   logic [7:0]       rd_ff;
   logic             sec_byp_ff;
   logic [7:0]       sec_data_ff;
   logic [7:0]       second;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] rd_full;
   logic [AW-1:0]    rd_addr;
   logic [CNT_W-1:0] wr_full;
   logic             mem_we;

   logic             out_free, has_top, has_sec;
   logic             want_push, push_ok, do_pop;
   logic             emit;
   logic [7:0]       e_sym;
   logic             e_last, e_term;
   prec_type         p_in;

   logic             rsp_valid_ff;
   logic [7:0]       rsp_sym_ff;
   logic             rsp_last_ff, rsp_term_ff, rsp_ovf_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign has_top  = (cnt_ff != '0);
   assign has_sec  = (cnt_ff > CNT_W'(1));
   assign second   = sec_byp_ff ? sec_data_ff : rd_ff;
   assign p_in     = prec_of(head_entry.symbol);

   always_comb begin
      deq       = 1'b0;
      want_push = 1'b0;
      do_pop    = 1'b0;
      emit      = 1'b0;
      e_sym     = top_ff;
      e_last    = 1'b0;
      e_term    = 1'b0;
      if (head_valid) begin
         case (head_entry.cls)
            CLS_DIGIT: begin
               if (out_free) begin
                  emit   = 1'b1;
                  e_sym  = head_entry.symbol;
                  e_last = 1'b1;
                  deq    = 1'b1;
               end
            end
            CLS_OPEN: begin
               want_push = 1'b1;
               deq       = 1'b1;
            end
            CLS_CLOSE: begin
               if (!has_top) begin
                  deq = 1'b1;
               end else if (top_ff == CH_LPAREN) begin
                  do_pop = 1'b1;
                  deq    = 1'b1;
               end else if (out_free) begin
                  emit   = 1'b1;
                  e_last = !(has_sec && (second != CH_LPAREN));
                  do_pop = 1'b1;
               end
            end
            CLS_OPER: begin
               if (has_top && (prec_of(top_ff) >= p_in)) begin
                  if (out_free) begin
                     emit   = 1'b1;
                     e_last = !(has_sec && (prec_of(second) >= p_in));
                     do_pop = 1'b1;
                  end
               end else begin
                  want_push = 1'b1;
                  deq       = 1'b1;
               end
            end
            CLS_END: begin
               if (has_top) begin
                  if (top_ff == CH_LPAREN) begin
                     do_pop = 1'b1;
                  end else if (out_free) begin
                     emit   = 1'b1;
                     do_pop = 1'b1;
                  end
               end else if (out_free) begin
                  emit   = 1'b1;
                  e_sym  = CH_NUL;
                  e_last = 1'b1;
                  e_term = 1'b1;
                  deq    = 1'b1;
               end
            end
            default: begin
               deq = 1'b1;
            end
         endcase
      end
   end

   // stack: top in a register, the rest in memory with a registered read of the
   // entry below the top
   always_comb begin
      push_ok = want_push && (cnt_ff != CNT_W'(STACK_DEPTH));
      ovf_in  = ovf_ff || (want_push && !push_ok);
      cnt_in  = cnt_ff;
      top_in  = top_ff;
      if (push_ok) begin
         cnt_in = cnt_ff + CNT_W'(1);
         top_in = head_entry.symbol;
      end else if (do_pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
         top_in = second;
      end
      rd_full = (cnt_in > CNT_W'(1)) ? cnt_in - CNT_W'(2) : '0;
      rd_addr = rd_full[AW-1:0];
      wr_full = cnt_ff - CNT_W'(1);
      mem_we  = push_ok && has_top;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      sec_byp_ff  <= push_ok;
      sec_data_ff <= top_ff;
      rd_ff       <= mem[rd_addr];
      if (mem_we) begin
         mem[wr_full[AW-1:0]] <= top_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_sym_ff  <= e_sym;
         rsp_last_ff <= e_last;
         rsp_term_ff <= e_term;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_symbol    = rsp_sym_ff;
   assign rsp_last_of_run   = rsp_last_ff;
   assign rsp_terminator    = rsp_term_ff;
   assign rsp_overflow_seen = rsp_ovf_ff;

   `ITP_ASSERT(a_cnt_range, cnt_ff <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
   `ITP_ASSERT(a_ovf_sticky, ovf_ff |=> ovf_ff, "overflow flag cleared")
   `ITP_ASSERT(a_pop_dec, do_pop |=> (cnt_ff == $past(cnt_ff) - CNT_W'(1)), "pop lost")
   `ITP_ASSERT(a_term_last, rsp_term_ff |-> (rsp_last_ff && rsp_sym_ff == CH_NUL), "bad end")
   `ITP_NEVER(a_pop_empty, do_pop && !has_top, "pop on empty stack")

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
// Top level of the shunting-yard infix to postfix converter.
// Characters enter on the req_ channel and are classified at once into a
// four-entry queue; characters that are not digits, parentheses, operators
// or an end item are dropped there and cost no further cycles. The stack
// engine takes one step per cycle from the queue when not stalled. A digit
// is emitted, '(' pushed, an operator pops and emits each stacked operator
// of equal or higher precedence before its push, ')' pops and emits up to
// the matching '(' and drops it, and an end item pops every entry, emitting
// all but '(', then emits the terminator. Every result leaves through an
// output register in the cycle after its step, so a result waiting on
// rsp_ready stalls only steps that produce results. At most one entry is
// popped per step. No clearing pass is needed after reset.
module infix_to_postfix_converter
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_symbol,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_symbol,
   output logic       rsp_last_of_run,
   output logic       rsp_terminator,
   output logic       rsp_overflow_seen
);

   logic      queue_full;
   logic      enq_valid;
   entry_type enq_entry;
   logic      deq;
   logic      head_valid;
   entry_type head_entry;

   itp_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_symbol       (req_symbol),
      .req_end_of_input (req_end_of_input),
      .queue_full       (queue_full),
      .enq_valid        (enq_valid),
      .enq_entry        (enq_entry)
   );

   itp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .enq_valid  (enq_valid),
      .enq_entry  (enq_entry),
      .full       (queue_full),
      .deq        (deq),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   itp_exec #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_exec (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .deq               (deq),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_symbol    (rsp_out_symbol),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_terminator    (rsp_terminator),
      .rsp_overflow_seen (rsp_overflow_seen)
   );

endmodule
